FILE: src/ilsi_pkg.sv
`timescale 1ns / 1ps

package ilsi_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OP_BITS     = 3;
    localparam int INDEX_BITS  = 6;
    localparam int DATA_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;

    typedef enum logic [OP_BITS-1:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // per-request command broadcast to every cell
    typedef struct packed {
        logic load;   // load the new value at pos
        logic ins;    // insert at pos, shift up
        logic rem;    // remove at pos, shift down
        logic rd;     // capture entry at pos
    } ctl_t;

endpackage

FILE: src/ilsi_cell.sv
`timescale 1ns / 1ps

module ilsi_cell #(
    parameter int VALUE_BITS = ilsi_pkg::VALUE_BITS_DEF,
    parameter int CMP_W      = ilsi_pkg::INDEX_BITS + 1,
    parameter int POS        = 0
) (
    input  logic                  clk,
    input  ilsi_pkg::ctl_t        ctl,
    input  logic [CMP_W-1:0]      pos,
    input  logic [CMP_W-1:0]      cnt,
    input  logic [VALUE_BITS-1:0] wval,
    input  logic [VALUE_BITS-1:0] left,
    input  logic [VALUE_BITS-1:0] right,
    output logic [VALUE_BITS-1:0] data,
    output logic [VALUE_BITS-1:0] rd_data
);

    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(POS);

    logic [VALUE_BITS-1:0] data_reg;
    logic [VALUE_BITS-1:0] data_next;
    logic [VALUE_BITS-1:0] rd_reg;
    logic [VALUE_BITS-1:0] rd_next;
    logic                  at_pos;
    logic                  above_pos;
    logic                  below_last;

    assign at_pos     = (MY_POS == pos);
    assign above_pos  = (MY_POS > pos);
    // this cell is below count - 1, so its right neighbor holds a live entry
    assign below_last = ((CMP_W + 1)'(MY_POS) + (CMP_W + 1)'(1)) < (CMP_W + 1)'(cnt);

    always_comb
    begin
        data_next = data_reg;
        if ((ctl.load || ctl.ins) && at_pos)
        begin
            data_next = wval;
        end
        else if (ctl.ins && above_pos && (MY_POS <= cnt))
        begin
            data_next = left;
        end
        else if (ctl.rem && (at_pos || above_pos) && below_last)
        begin
            data_next = right;
        end
    end

    assign rd_next = (ctl.rd && at_pos) ? data_reg : '0;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data    = data_reg;
    assign rd_data = rd_reg;

endmodule

FILE: src/indexed_list_shift_insert_remove_core.sv
`timescale 1ns / 1ps
// Result: the strobe (done) is high for one cycle; a request is registered in pend_reg
// and then in done_reg, and the receiver cannot stall it.
// Requests: no new request is taken while busy; busy is high the cycle after a request
// while the cells' read registers are OR-reduced into the output register.
// Every operation, shifts included, is applied to the cell row when the request is accepted.
// Reset: count clears to zero and the list is empty; entries are not cleared.

module indexed_list_shift_insert_remove_core #(
    parameter int DEPTH      = ilsi_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = ilsi_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ilsi_pkg::OP_BITS-1:0]       op,
    input  logic [ilsi_pkg::INDEX_BITS-1:0]    index,
    input  logic [ilsi_pkg::DATA_BITS-1:0]     value,
    output logic                               busy,
    output logic                               done,
    output logic [ilsi_pkg::DATA_BITS-1:0]     read_value,
    output logic [ilsi_pkg::STATUS_BITS-1:0]   status,
    output logic [ilsi_pkg::COUNT_BITS-1:0]    count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > ilsi_pkg::INDEX_BITS) ? CNT_W : ilsi_pkg::INDEX_BITS;
    localparam int DB    = ilsi_pkg::DATA_BITS;

    logic                   accept;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   pend_reg;
    logic                   done_reg;
    ilsi_pkg::status_t      st_pend_reg;
    ilsi_pkg::status_t      st_next;
    ilsi_pkg::status_t      status_reg;
    logic [CNT_W-1:0]       cnt_out_reg;
    logic [DB-1:0]          rd_out_reg;

    ilsi_pkg::ctl_t         ctl_next;
    ilsi_pkg::ctl_t         ctl;
    logic [CMP_W-1:0]       pos;
    logic [CMP_W-1:0]       idx_x;
    logic [CMP_W-1:0]       cnt_x;
    logic                   idx_ok;
    logic                   full;

    logic [VALUE_BITS+DB-1:0] wval_ext;
    logic [VALUE_BITS-1:0]    wval;
    logic [VALUE_BITS-1:0]    cell_data [DEPTH];
    logic [VALUE_BITS-1:0]    cell_rd   [DEPTH];
    logic [VALUE_BITS-1:0]    rd_or;
    logic [VALUE_BITS+DB-1:0] rd_ext;

    assign accept = start && !pend_reg;
    assign busy   = pend_reg;

    assign idx_x  = CMP_W'(index);
    assign cnt_x  = CMP_W'(count_reg);
    assign idx_ok = idx_x < cnt_x;
    assign full   = (count_reg >= CNT_W'(DEPTH));

    // value masked (or zero-extended) to the stored word width
    assign wval_ext = {{VALUE_BITS{1'b0}}, value};
    assign wval     = wval_ext[VALUE_BITS-1:0];

    always_comb
    begin
        ctl_next   = '0;
        st_next    = ilsi_pkg::ST_DONE;
        count_next = count_reg;
        pos        = idx_x;
        unique case (op)
            ilsi_pkg::OP_WRITE:
            begin
                if (idx_ok) ctl_next.load = 1'b1;
                else        st_next = ilsi_pkg::ST_INDEX;
            end
            ilsi_pkg::OP_READ:
            begin
                if (idx_ok) ctl_next.rd = 1'b1;
                else        st_next = ilsi_pkg::ST_INDEX;
            end
            ilsi_pkg::OP_APPEND:
            begin
                pos = cnt_x;
                if (full)
                begin
                    st_next = ilsi_pkg::ST_FULL;
                end
                else
                begin
                    ctl_next.load = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            ilsi_pkg::OP_INSERT:
            begin
                priority if (!idx_ok)
                begin
                    st_next = ilsi_pkg::ST_INDEX;
                end
                else if (full)
                begin
                    st_next = ilsi_pkg::ST_FULL;
                end
                else
                begin
                    ctl_next.ins = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            ilsi_pkg::OP_REMOVE:
            begin
                if (idx_ok)
                begin
                    ctl_next.rem = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                begin
                    st_next = ilsi_pkg::ST_INDEX;
                end
            end
            default: ;  // unknown op: no change, status done
        endcase
    end

    assign ctl = accept ? ctl_next : '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_w;
        logic [VALUE_BITS-1:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_data[i+1];
        end

        ilsi_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CMP_W      (CMP_W),
            .POS        (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .pos     (pos),
            .cnt     (cnt_x),
            .wval    (wval),
            .left    (left_w),
            .right   (right_w),
            .data    (cell_data[i]),
            .rd_data (cell_rd[i])
        );
    end

    // at most one cell holds a nonzero read word
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    assign rd_ext = {{DB{1'b0}}, rd_or};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            st_pend_reg <= ilsi_pkg::ST_DONE;
            status_reg  <= ilsi_pkg::ST_DONE;
            cnt_out_reg <= '0;
        end
        else
        begin
            pend_reg <= accept;
            done_reg <= pend_reg;
            if (accept)
            begin
                count_reg   <= count_next;
                st_pend_reg <= st_next;
            end
            if (pend_reg)
            begin
                status_reg  <= st_pend_reg;
                cnt_out_reg <= count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            rd_out_reg <= rd_ext[DB-1:0];
        end
    end

    assign done       = done_reg;
    assign read_value = rd_out_reg;
    assign status     = status_reg;
    assign count      = ilsi_pkg::COUNT_BITS'(cnt_out_reg);

`ifndef SYNTHESIS
    a_done_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(pend_reg))
        else $error("result strobe without a request in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ilsi_pkg::ST_FULL) |-> (cnt_out_reg == CNT_W'(DEPTH)))
        else $error("full status with list not full");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> !pend_reg)
        else $error("request accepted while busy");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LIST_DEPTH = ilsi_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 4;
    localparam logic [ilsi_pkg::OP_BITS-1:0] OP_NONE_FIRST = 3'd5;
    localparam logic [ilsi_pkg::OP_BITS-1:0] OP_NONE_MID = 3'd6;
    localparam logic [ilsi_pkg::OP_BITS-1:0] OP_NONE_LAST = 3'd7;

    typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_kind_t;

    typedef struct {
        logic [ilsi_pkg::OP_BITS-1:0]    opc;
        logic [ilsi_pkg::INDEX_BITS-1:0] idx;
        logic [ilsi_pkg::DATA_BITS-1:0]  data;
    } list_req_t;

    typedef struct {
        logic [ilsi_pkg::DATA_BITS-1:0]  rdata;
        ilsi_pkg::status_t               st;
        logic [ilsi_pkg::COUNT_BITS-1:0] len;
    } list_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic [ilsi_pkg::OP_BITS-1:0]     op;
    logic [ilsi_pkg::INDEX_BITS-1:0]  index;
    logic [ilsi_pkg::DATA_BITS-1:0]   value;
    logic                             busy;
    logic                             done;
    logic [ilsi_pkg::DATA_BITS-1:0]   read_value;
    logic [ilsi_pkg::STATUS_BITS-1:0] status;
    logic [ilsi_pkg::COUNT_BITS-1:0]  count;

    indexed_list_shift_insert_remove_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .index      (index),
        .value      (value),
        .busy       (busy),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    // list model state
    logic [ilsi_pkg::DATA_BITS-1:0]  list_mem [LIST_DEPTH];
    logic [ilsi_pkg::COUNT_BITS-1:0] list_len;

    list_req_t    req_q[$];
    list_result_t result_q[$];

    int n_items;
    int n_accepted;
    int errors;
    int gen_len;
    int gap_left;
    int calm_left;
    int cycles;
    int op_seen [8];
    int full_refusals;
    int index_refusals;
    int peak_len;
    logic take;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic list_result_t list_apply(logic [ilsi_pkg::OP_BITS-1:0] opc,
                                                logic [ilsi_pkg::INDEX_BITS-1:0] idx,
                                                logic [ilsi_pkg::DATA_BITS-1:0] data);
        list_result_t r;
        bit idx_ok;
        int i;
        r.rdata = '0;
        r.st = ilsi_pkg::ST_DONE;
        idx_ok = ilsi_pkg::COUNT_BITS'(idx) < list_len;
        case (opc)
            ilsi_pkg::OP_WRITE:
            begin
                if (idx_ok)
                    list_mem[idx] = data;
                else
                    r.st = ilsi_pkg::ST_INDEX;
            end
            ilsi_pkg::OP_READ:
            begin
                if (idx_ok)
                    r.rdata = list_mem[idx];
                else
                    r.st = ilsi_pkg::ST_INDEX;
            end
            ilsi_pkg::OP_APPEND:
            begin
                if (int'(list_len) >= LIST_DEPTH)
                    r.st = ilsi_pkg::ST_FULL;
                else
                begin
                    list_mem[list_len[ilsi_pkg::INDEX_BITS-1:0]] = data;
                    list_len = list_len + ilsi_pkg::COUNT_BITS'(1);
                end
            end
            ilsi_pkg::OP_INSERT:
            begin
                // index check wins over full
                if (!idx_ok)
                    r.st = ilsi_pkg::ST_INDEX;
                else if (int'(list_len) >= LIST_DEPTH)
                    r.st = ilsi_pkg::ST_FULL;
                else
                begin
                    for (i = int'(list_len); i > int'(idx); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[idx] = data;
                    list_len = list_len + ilsi_pkg::COUNT_BITS'(1);
                end
            end
            ilsi_pkg::OP_REMOVE:
            begin
                if (!idx_ok)
                    r.st = ilsi_pkg::ST_INDEX;
                else
                begin
                    for (i = int'(idx); i + 1 < int'(list_len); i++)
                        list_mem[i] = list_mem[i+1];
                    list_len = list_len - ilsi_pkg::COUNT_BITS'(1);
                end
            end
            default: ;
        endcase
        r.len = list_len;
        return r;
    endfunction

    // queue a request; gen_len tracks only the entry count for index choice
    task automatic add_req(logic [ilsi_pkg::OP_BITS-1:0] opc,
                           logic [ilsi_pkg::INDEX_BITS-1:0] idx,
                           logic [ilsi_pkg::DATA_BITS-1:0] data);
        list_req_t q;
        q.opc = opc;
        q.idx = idx;
        q.data = data;
        req_q.push_back(q);
        n_items++;
        case (opc)
            ilsi_pkg::OP_APPEND:
                if (gen_len < LIST_DEPTH)
                    gen_len++;
            ilsi_pkg::OP_INSERT:
                if (int'(idx) < gen_len && gen_len < LIST_DEPTH)
                    gen_len++;
            ilsi_pkg::OP_REMOVE:
                if (int'(idx) < gen_len)
                    gen_len--;
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= '0;
            index <= '0;
            value <= '0;
            gap_left = 0;
            calm_left = 0;
            list_len = '0;
        end
        else
        begin
            take = start && !busy;
            if (take)
            begin
                list_result_t r;
                r = list_apply(op, index, value);
                result_q.push_back(r);
                n_accepted++;
                op_seen[op]++;
                if (r.st == ilsi_pkg::ST_FULL)
                    full_refusals++;
                if (r.st == ilsi_pkg::ST_INDEX)
                    index_refusals++;
                if (int'(r.len) > peak_len)
                    peak_len = int'(r.len);
                if (calm_left != 0)
                begin
                    calm_left--;
                    gap_left = 0;
                end
                else
                begin
                    int sel;
                    sel = $urandom_range(0, 99);
                    if (sel < 5)
                        calm_left = $urandom_range(20, 40);
                    if (sel < 55)
                        gap_left = 0;
                    else if (sel < 92)
                        gap_left = $urandom_range(1, 3);
                    else
                        gap_left = $urandom_range(8, 30);
                end
            end
            if (!start || take)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (req_q.size() != 0)
                begin
                    list_req_t q;
                    q = req_q.pop_front();
                    op <= q.opc;
                    index <= q.idx;
                    value <= q.data;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (result_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: read_value=%h status=%0d count=%0d",
                             read_value, status, count);
            end
            else
            begin
                list_result_t e;
                e = result_q.pop_front();
                if (read_value !== e.rdata || status !== e.st || count !== e.len)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: read_value %h/%h status %0d/%0d ",
                                  "count %0d/%0d (exp/act)"},
                                 e.rdata, read_value, e.st, status, e.len, count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        phase_kind_t kind;
        int p;
        int k;
        int plen;
        int sel;
        logic [ilsi_pkg::OP_BITS-1:0] opc;
        logic [ilsi_pkg::INDEX_BITS-1:0] idx;
        logic [ilsi_pkg::DATA_BITS-1:0] data;

        rst_n = 1'b0;
        n_items = 0;
        n_accepted = 0;
        errors = 0;
        gen_len = 0;
        cycles = 0;
        full_refusals = 0;
        index_refusals = 0;
        peak_len = 0;
        foreach (op_seen[i])
            op_seen[i] = 0;

        // directed: refusals on an empty list, ignored ops, edges of the list
        add_req(ilsi_pkg::OP_READ, 6'd0, 32'h0);
        add_req(ilsi_pkg::OP_WRITE, 6'd0, 32'hFFFF_FFFF);
        add_req(ilsi_pkg::OP_INSERT, 6'd0, 32'h1);
        add_req(ilsi_pkg::OP_REMOVE, 6'd63, 32'h0);
        add_req(OP_NONE_FIRST, 6'd0, 32'hDEAD_BEEF);
        add_req(OP_NONE_MID, 6'd63, 32'h0);
        add_req(OP_NONE_LAST, 6'd21, 32'hFFFF_FFFF);
        add_req(ilsi_pkg::OP_APPEND, 6'd0, 32'h0000_0000);
        add_req(ilsi_pkg::OP_APPEND, 6'd63, 32'hFFFF_FFFF);
        add_req(ilsi_pkg::OP_INSERT, 6'd0, 32'h1234_5678);
        add_req(ilsi_pkg::OP_INSERT, 6'd2, 32'hA5A5_A5A5);
        add_req(ilsi_pkg::OP_READ, 6'd0, 32'h0);
        add_req(ilsi_pkg::OP_READ, 6'd3, 32'h0);
        add_req(ilsi_pkg::OP_WRITE, 6'd3, 32'h5A5A_5A5A);
        add_req(ilsi_pkg::OP_READ, 6'd3, 32'h0);
        add_req(ilsi_pkg::OP_READ, 6'd4, 32'h0);
        add_req(ilsi_pkg::OP_REMOVE, 6'd3, 32'h0);
        add_req(ilsi_pkg::OP_REMOVE, 6'd0, 32'h0);
        add_req(ilsi_pkg::OP_READ, 6'd0, 32'h0);
        add_req(ilsi_pkg::OP_WRITE, 6'd63, 32'h0);

        // random: fill to full, churn, drain, churn; twice
        for (p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    kind = PH_FILL;
                    plen = 70;
                end
                2:
                begin
                    kind = PH_DRAIN;
                    plen = 60;
                end
                default:
                begin
                    kind = PH_MIXED;
                    plen = 35;
                end
            endcase
            for (k = 0; k < plen; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 2)
                    opc = ilsi_pkg::OP_BITS'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST));
                else if (kind == PH_FILL)
                    opc = sel < 50 ? ilsi_pkg::OP_APPEND : sel < 90 ? ilsi_pkg::OP_INSERT :
                          sel < 95 ? ilsi_pkg::OP_READ : ilsi_pkg::OP_WRITE;
                else if (kind == PH_DRAIN)
                    opc = sel < 80 ? ilsi_pkg::OP_REMOVE :
                          sel < 90 ? ilsi_pkg::OP_READ : ilsi_pkg::OP_WRITE;
                else
                    opc = sel < 22 ? ilsi_pkg::OP_WRITE : sel < 44 ? ilsi_pkg::OP_READ :
                          sel < 60 ? ilsi_pkg::OP_APPEND :
                          sel < 78 ? ilsi_pkg::OP_INSERT : ilsi_pkg::OP_REMOVE;

                sel = $urandom_range(0, 99);
                if (sel < 75 && gen_len > 0)
                    idx = ilsi_pkg::INDEX_BITS'($urandom_range(0, gen_len - 1));
                else if (sel < 85)
                    idx = gen_len >= LIST_DEPTH ? ilsi_pkg::INDEX_BITS'(LIST_DEPTH - 1) :
                          ilsi_pkg::INDEX_BITS'(gen_len);
                else
                    idx = ilsi_pkg::INDEX_BITS'($urandom_range(0, LIST_DEPTH - 1));

                sel = $urandom_range(0, 99);
                data = sel < 4 ? 32'h0 : sel < 8 ? 32'hFFFF_FFFF : $urandom;
                add_req(opc, idx, data);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_items || result_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (result_q.size() != 0)
        begin
            errors++;
            $display("%0d results never arrived", result_q.size());
        end

        $display({"%0d requests: write %0d read %0d append %0d insert %0d ",
                  "remove %0d, %0d other ops"},
                 n_accepted, op_seen[ilsi_pkg::OP_WRITE], op_seen[ilsi_pkg::OP_READ],
                 op_seen[ilsi_pkg::OP_APPEND], op_seen[ilsi_pkg::OP_INSERT],
                 op_seen[ilsi_pkg::OP_REMOVE],
                 op_seen[OP_NONE_FIRST] + op_seen[OP_NONE_MID] + op_seen[OP_NONE_LAST]);
        $display("peak count %0d, %0d full refusals, %0d index refusals, %0d mismatches",
                 peak_len, full_refusals, index_refusals, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: indexed_list_shift_insert_remove_core.f
src/ilsi_pkg.sv
src/ilsi_cell.sv
src/indexed_list_shift_insert_remove_core.sv
tb/tb_top.sv
